// ===== design/csifb_pkg.sv =====
package csifb_pkg;

   // Fixed field widths of the transactions.
   localparam int BYTE_W     = 8;
   localparam int ANT_W      = 2;
   localparam int SC_OUT_W   = 5;
   localparam int IDX_W      = 2;

   // Internal counter widths. The subcarrier counter covers up to 64 groups.
   localparam int SC_CNT_W   = 6;
   localparam int HELD_W     = 4;
   localparam int ENTRY_W    = 4;

   // Default block configuration.
   localparam int SUBCARRIER_GROUPS_DEF = 30;
   localparam int MAX_ANTENNAS_DEF      = 3;
   localparam int SKIP_BITS_DEF         = 3;

   // One accepted input byte with its packet controls.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              packet_start;
      logic [ANT_W-1:0]  rx_antennas;
      logic [ANT_W-1:0]  tx_antennas;
   } item_type;

   // One decoded channel entry.
   typedef struct packed {
      logic signed [BYTE_W-1:0] real_part;
      logic signed [BYTE_W-1:0] imag_part;
      logic [SC_OUT_W-1:0]      subcarrier;
      logic [IDX_W-1:0]         tx_index;
      logic [IDX_W-1:0]         rx_index;
      logic                     last_entry;
   } result_type;

   // Parser status seen by the top level.
   typedef struct packed {
      logic             packet_done;
      logic [ANT_W-1:0] rx_count;
      logic [ANT_W-1:0] tx_count;
   } status_type;

endpackage

// ===== design/csifb_if.sv =====
// Request channel: one payload byte per transaction.
interface csifb_req_if import csifb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              packet_start;
   logic [ANT_W-1:0]  rx_antennas;
   logic [ANT_W-1:0]  tx_antennas;

   modport source (output valid, data_byte, packet_start, rx_antennas, tx_antennas,
                   input ready);
   modport sink   (input valid, data_byte, packet_start, rx_antennas, tx_antennas,
                   output ready);
endinterface

// Response channel: one decoded channel entry per transaction.
interface csifb_rsp_if import csifb_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [BYTE_W-1:0] real_part;
   logic signed [BYTE_W-1:0] imag_part;
   logic [SC_OUT_W-1:0]      subcarrier;
   logic [IDX_W-1:0]         tx_index;
   logic [IDX_W-1:0]         rx_index;
   logic                     last_entry;

   modport source (output valid, real_part, imag_part, subcarrier, tx_index, rx_index,
                   last_entry, input ready);
   modport sink   (input valid, real_part, imag_part, subcarrier, tx_index, rx_index,
                   last_entry, output ready);
endinterface

// ===== design/csifb_in_reg.sv =====
module csifb_in_reg import csifb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   csifb_req_if.sink    req_bus,
   input  logic         advance,
   output logic         item_valid,
   output item_type     item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   // The register can take a new byte when empty or when its byte moves on.
   assign req_bus.ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_bus.valid && req_bus.ready) begin
         valid_in = 1'b1;
         item_in  = '{data_byte:    req_bus.data_byte,
                      packet_start: req_bus.packet_start,
                      rx_antennas:  req_bus.rx_antennas,
                      tx_antennas:  req_bus.tx_antennas};
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/csifb_core.sv =====
module csifb_core import csifb_pkg::*; #(
   parameter int SUBCARRIER_GROUPS = SUBCARRIER_GROUPS_DEF,
   parameter int MAX_ANTENNAS      = MAX_ANTENNAS_DEF,
   parameter int SKIP_BITS         = SKIP_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   output logic       produced,
   output result_type result,
   output status_type status
);

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_REAL,
      PH_IMAG
   } phase_type;

   localparam logic [HELD_W-1:0]   HELD_FULL = HELD_W'(BYTE_W);
   localparam logic [HELD_W-1:0]   SKIP_LEN  = HELD_W'(SKIP_BITS);
   localparam logic [ANT_W:0]      MAX_ANT   = (ANT_W+1)'(MAX_ANTENNAS);
   localparam logic [SC_CNT_W:0]   SC_GROUPS = (SC_CNT_W+1)'(SUBCARRIER_GROUPS);
   localparam phase_type           START_PH  = (SKIP_BITS > 0) ? PH_SKIP : PH_REAL;

   phase_type           phase_ff, phase_in;
   logic [HELD_W-1:0]   held_ff, held_in;
   logic [BYTE_W-1:0]   bits_ff, bits_in;
   logic [BYTE_W-1:0]   real_ff, real_in;
   logic [SC_CNT_W-1:0] sc_ff, sc_in;
   logic [ENTRY_W-1:0]  ec_ff, ec_in;
   logic [ANT_W-1:0]    rx_ff, rx_in;
   logic [ANT_W-1:0]    tx_ff, tx_in;
   logic                done_ff, done_in;
   logic [ENTRY_W-1:0]  total;
   logic                last_sc;
   logic                last_en;
   logic [2*IDX_W-1:0]  split;

   // A count of zero reads as one, and counts above the limit are capped.
   function automatic logic [ANT_W-1:0] clamp_count(input logic [ANT_W-1:0] v);
      logic [ANT_W-1:0] c;
      c = (v == '0) ? ANT_W'(1) : v;
      if ({1'b0, c} > MAX_ANT) begin
         c = MAX_ANT[ANT_W-1:0];
      end
      return c;
   endfunction

   // Entry number to {tx, rx}: quotient and remainder by the rx count.
   // Division by three uses the reciprocal 11/32, exact for 4-bit values.
   function automatic logic [2*IDX_W-1:0] split_entry(input logic [ENTRY_W-1:0] e,
                                                       input logic [ANT_W-1:0]   n);
      logic [7:0]         prod;
      logic [ENTRY_W-1:0] q;
      logic [ENTRY_W-1:0] r;
      prod = 8'(e) * 8'd11;
      case (n)
         2'd2:    q = e >> 1;
         2'd3:    q = ENTRY_W'(prod[7:5]);
         default: q = e;
      endcase
      r = e - ENTRY_W'(q * ENTRY_W'(n));
      return {q[IDX_W-1:0], r[IDX_W-1:0]};
   endfunction

   // Walk the eight bits of the byte through the field parser.
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      bits_in  = bits_ff;
      real_in  = real_ff;
      sc_in    = sc_ff;
      ec_in    = ec_ff;
      rx_in    = rx_ff;
      tx_in    = tx_ff;
      done_in  = done_ff;
      produced = 1'b0;
      result   = '0;
      total    = '0;
      last_sc  = 1'b0;
      last_en  = 1'b0;
      split    = '0;

      if (item.packet_start) begin
         rx_in    = clamp_count(item.rx_antennas);
         tx_in    = clamp_count(item.tx_antennas);
         bits_in  = '0;
         held_in  = '0;
         real_in  = '0;
         sc_in    = '0;
         ec_in    = '0;
         phase_in = START_PH;
         done_in  = 1'b0;
      end

      for (int k = 0; k < BYTE_W; k++) begin
         if (!done_in) begin
            if (phase_in == PH_REAL || phase_in == PH_IMAG) begin
               bits_in[held_in[2:0]] = item.data_byte[k[2:0]];
               held_in = held_in + 1'b1;
               if (held_in == HELD_FULL) begin
                  if (phase_in == PH_REAL) begin
                     real_in  = bits_in;
                     bits_in  = '0;
                     held_in  = '0;
                     phase_in = PH_IMAG;
                  end else begin
                     total   = ENTRY_W'(rx_in) * ENTRY_W'(tx_in);
                     last_sc = ({1'b0, sc_in} + 1'b1) >= SC_GROUPS;
                     last_en = ({1'b0, ec_in} + 1'b1) >= {1'b0, total};
                     split   = split_entry(ec_in, rx_in);
                     result.real_part  = real_in;
                     result.imag_part  = bits_in;
                     result.subcarrier = sc_in[SC_OUT_W-1:0];
                     result.tx_index   = split[2*IDX_W-1:IDX_W];
                     result.rx_index   = split[IDX_W-1:0];
                     result.last_entry = last_sc && last_en;
                     produced = 1'b1;
                     bits_in  = '0;
                     held_in  = '0;
                     if (last_en) begin
                        ec_in = '0;
                        if (last_sc) begin
                           done_in  = 1'b1;
                           phase_in = PH_SKIP;
                        end else begin
                           sc_in    = sc_in + 1'b1;
                           phase_in = START_PH;
                        end
                     end else begin
                        ec_in    = ec_in + 1'b1;
                        phase_in = PH_REAL;
                     end
                  end
               end
            end else begin
               // Skip field ahead of each subcarrier.
               held_in = held_in + 1'b1;
               if (held_in >= SKIP_LEN) begin
                  held_in  = '0;
                  bits_in  = '0;
                  phase_in = PH_REAL;
               end
            end
         end
      end
   end

   // Parser state moves only when the byte in the input register is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         held_ff  <= '0;
         bits_ff  <= '0;
         real_ff  <= '0;
         sc_ff    <= '0;
         ec_ff    <= '0;
         rx_ff    <= ANT_W'(1);
         tx_ff    <= ANT_W'(1);
         done_ff  <= 1'b1;
      end else if (advance) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         bits_ff  <= bits_in;
         real_ff  <= real_in;
         sc_ff    <= sc_in;
         ec_ff    <= ec_in;
         rx_ff    <= rx_in;
         tx_ff    <= tx_in;
         done_ff  <= done_in;
      end
   end

   assign status = '{packet_done: done_ff, rx_count: rx_ff, tx_count: tx_ff};

endmodule

// ===== design/csifb_out_reg.sv =====
module csifb_out_reg import csifb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   csifb_rsp_if.source  rsp_bus,
   input  logic         advance,
   input  logic         produced,
   input  result_type   result,
   output logic         slot_free
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // The register is free when empty or when its entry is taken this cycle.
   assign slot_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff && !rsp_bus.ready;
      data_in  = data_ff;
      if (advance) begin
         valid_in = produced;
         if (produced) begin
            data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.real_part  = data_ff.real_part;
   assign rsp_bus.imag_part  = data_ff.imag_part;
   assign rsp_bus.subcarrier = data_ff.subcarrier;
   assign rsp_bus.tx_index   = data_ff.tx_index;
   assign rsp_bus.rx_index   = data_ff.rx_index;
   assign rsp_bus.last_entry = data_ff.last_entry;

endmodule

// ===== design/csi_feedback_bit_unpacker_top.sv =====
// Channel-state feedback unpacker.
// The req_bus channel carries the feedback payload one byte per transaction,
// bits read least significant first. packet_start marks the first byte of a
// payload and samples the rx and tx antenna counts. For each subcarrier group
// the skip bits are dropped, then rx*tx entries of a signed 8-bit real and a
// signed 8-bit imaginary part are read. Each completed entry leaves on the
// rsp_bus channel with its subcarrier, tx and rx index and a last flag.
// Bytes after the last entry, or before the first start, are dropped.
// A byte accepted into the input register is parsed, and its entry, if any, is
// registered in the result register for rsp_bus. Throughput: one byte per cycle
// while the receiver takes entries; the eight-bit walk of the field parser sets it.
// Reset empties both registers and leaves the parser idle until a start.
// When the receiver stalls, the pending entry holds, one more byte waits in the
// input register, and then req_bus.ready drops until the entry is taken.
module csi_feedback_bit_unpacker_top import csifb_pkg::*; #(
   parameter int SUBCARRIER_GROUPS = SUBCARRIER_GROUPS_DEF,
   parameter int MAX_ANTENNAS      = MAX_ANTENNAS_DEF,
   parameter int SKIP_BITS         = SKIP_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   csifb_req_if.sink    req_bus,
   csifb_rsp_if.source  rsp_bus
);

   logic       item_valid;
   item_type   item;
   logic       advance;
   logic       slot_free;
   logic       produced;
   result_type result;
   status_type status;

   // A byte is parsed when it is held and its result has room.
   assign advance = item_valid && slot_free;

   csifb_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   csifb_core #(
      .SUBCARRIER_GROUPS (SUBCARRIER_GROUPS),
      .MAX_ANTENNAS      (MAX_ANTENNAS),
      .SKIP_BITS         (SKIP_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .item     (item),
      .produced (produced),
      .result   (result),
      .status   (status)
   );

   csifb_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .rsp_bus   (rsp_bus),
      .advance   (advance),
      .produced  (produced),
      .result    (result),
      .slot_free (slot_free)
   );

   // A pending final entry means the parser has closed the packet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.last_entry |-> status.packet_done)
      else $error("last entry pending while parser still open");

   // Pending indices stay within the antenna counts of their packet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.rx_index < status.rx_count) &&
                        (rsp_bus.tx_index < status.tx_count))
      else $error("entry index outside antenna counts");

   // A held byte that cannot move on is kept for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      item_valid && !slot_free |=> item_valid)
      else $error("stalled input byte lost");

endmodule

// ===== tb/csi_feedback_bit_unpacker_top_tb.sv =====
module csi_feedback_bit_unpacker_top_tb import csifb_pkg::*; ();

   localparam int GROUPS         = SUBCARRIER_GROUPS_DEF;
   localparam int ANT_LIMIT      = MAX_ANTENNAS_DEF;
   localparam int SKIP_LEN       = SKIP_BITS_DEF;
   localparam int RANDOM_BYTES   = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int PRINT_LIMIT    = 40;

   typedef enum logic [1:0] {SKIP_FIELD, REAL_FIELD, IMAG_FIELD} field_phase_type;
   typedef enum logic {SINK_STEADY, SINK_BURSTY} sink_style_type;

   logic clock = 1'b0;
   logic reset;

   csifb_req_if req_bus ();
   csifb_rsp_if rsp_bus ();

   csi_feedback_bit_unpacker_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   // Shadow copy of the parser state.
   field_phase_type   parse_phase;
   logic [BYTE_W-1:0] field_bits;
   logic [BYTE_W-1:0] real_hold;
   int                field_pos;
   int                sc_idx;
   int                entry_idx;
   int                ant_rx;
   int                ant_tx;
   logic              parse_idle;

   // Entries still owed by the block, oldest first.
   result_type expected_entries[$];

   // Bit stream under construction for the directed tests.
   bit field_stream[$];

   // Traffic shaping on both channels.
   logic           source_steady;
   int             burst_left;
   sink_style_type sink_style;
   logic           sink_open;
   int             sink_left;

   int error_count;
   int bytes_sent;
   int starts_sent;
   int entries_checked;
   int packets_finished;
   int idle_cycles;
   result_type wanted;

   task automatic report_error(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // A raw count of zero means one antenna; counts saturate at the limit.
   function automatic int clamp_antennas(input logic [ANT_W-1:0] raw);
      int c;
      c = int'(raw);
      if (c == 0)
         c = 1;
      if (c > ANT_LIMIT)
         c = ANT_LIMIT;
      return c;
   endfunction

   // Walks one accepted byte through the field parser, LSB first, and queues
   // the entry that it completes, if any.
   function automatic void predict_byte(input item_type it);
      result_type e;
      logic       last_sc;
      logic       last_en;
      if (it.packet_start) begin
         ant_rx      = clamp_antennas(it.rx_antennas);
         ant_tx      = clamp_antennas(it.tx_antennas);
         field_bits  = '0;
         field_pos   = 0;
         real_hold   = '0;
         sc_idx      = 0;
         entry_idx   = 0;
         parse_phase = (SKIP_LEN > 0) ? SKIP_FIELD : REAL_FIELD;
         parse_idle  = 1'b0;
      end
      for (int k = 0; k < BYTE_W; k++) begin
         if (!parse_idle) begin
            if (parse_phase == REAL_FIELD || parse_phase == IMAG_FIELD) begin
               field_bits[field_pos[2:0]] = it.data_byte[k[2:0]];
               field_pos++;
               if (field_pos == BYTE_W) begin
                  if (parse_phase == REAL_FIELD) begin
                     real_hold   = field_bits;
                     parse_phase = IMAG_FIELD;
                  end else begin
                     last_sc      = (sc_idx + 1 >= GROUPS);
                     last_en      = (entry_idx + 1 >= ant_rx * ant_tx);
                     e.real_part  = real_hold;
                     e.imag_part  = field_bits;
                     e.subcarrier = SC_OUT_W'(sc_idx);
                     e.tx_index   = IDX_W'(entry_idx / ant_rx);
                     e.rx_index   = IDX_W'(entry_idx % ant_rx);
                     e.last_entry = last_sc && last_en;
                     expected_entries.insert(expected_entries.size(), e);
                     if (last_en) begin
                        entry_idx = 0;
                        if (last_sc) begin
                           parse_idle  = 1'b1;
                           parse_phase = SKIP_FIELD;
                        end else begin
                           sc_idx++;
                           parse_phase = (SKIP_LEN > 0) ? SKIP_FIELD : REAL_FIELD;
                        end
                     end else begin
                        entry_idx++;
                        parse_phase = REAL_FIELD;
                     end
                  end
                  field_bits = '0;
                  field_pos  = 0;
               end
            end else begin
               // Skip phase: the bits are dropped, only the count matters.
               field_pos++;
               if (field_pos >= SKIP_LEN) begin
                  field_pos   = 0;
                  field_bits  = '0;
                  parse_phase = REAL_FIELD;
               end
            end
         end
      end
   endfunction

   // Sends one byte on the request channel and predicts it once the
   // transaction completes. Called and returns at a falling edge.
   task automatic send_byte(input item_type it);
      int gap;
      if (!source_steady && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = $urandom_range(0, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.data_byte    <= it.data_byte;
      req_bus.packet_start <= it.packet_start;
      req_bus.rx_antennas  <= it.rx_antennas;
      req_bus.tx_antennas  <= it.tx_antennas;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predict_byte(it);
      bytes_sent++;
      if (it.packet_start)
         starts_sent++;
      @(negedge clock);
   endtask

   function automatic void stream_put(input int value, input int width);
      for (int i = 0; i < width; i++)
         field_stream.insert(field_stream.size(), value[i[4:0]]);
   endfunction

   // Packs the queued bits into bytes; the first byte opens a packet.
   task automatic stream_send(input logic [ANT_W-1:0] rx, input logic [ANT_W-1:0] tx);
      item_type it;
      int       n;
      n = 0;
      while (field_stream.size() > 0) begin
         it.data_byte = '0;
         for (int i = 0; i < BYTE_W; i++)
            if (field_stream.size() > 0)
               it.data_byte[i[2:0]] = field_stream.pop_front();
         it.packet_start = (n == 0);
         it.rx_antennas  = rx;
         it.tx_antennas  = tx;
         send_byte(it);
         n++;
      end
   endtask

   task automatic send_raw(input logic [BYTE_W-1:0] data, input logic start,
                           input logic [ANT_W-1:0] rx, input logic [ANT_W-1:0] tx);
      item_type it;
      it.data_byte    = data;
      it.packet_start = start;
      it.rx_antennas  = rx;
      it.tx_antennas  = tx;
      send_byte(it);
   endtask

   // Bytes that arrive before any packet start are dropped.
   task automatic test_bytes_before_start();
      send_raw(8'hFF, 1'b0, 2'd3, 2'd3);
      send_raw(8'h00, 1'b0, 2'd0, 2'd0);
      send_raw(8'h80, 1'b0, 2'd2, 2'd1);
   endtask

   // Extreme real and imaginary values with a zero rx count, clamped to one.
   task automatic test_value_extremes();
      stream_put(7, SKIP_LEN);
      stream_put(-128, BYTE_W);
      stream_put(127, BYTE_W);
      stream_put(127, BYTE_W);
      stream_put(-128, BYTE_W);
      stream_put(-1, BYTE_W);
      stream_put(0, BYTE_W);
      stream_send(2'd0, 2'd3);
   endtask

   // Three rx antennas and a zero tx count, with all-zero and all-one bytes.
   task automatic test_zero_tx_count();
      send_raw(8'hFF, 1'b1, 2'd3, 2'd0);
      send_raw(8'h00, 1'b0, 2'd1, 2'd2);
      send_raw(8'hA5, 1'b0, 2'd0, 2'd3);
      send_raw(8'h5A, 1'b0, 2'd2, 2'd1);
      send_raw(8'hFF, 1'b0, 2'd3, 2'd3);
      send_raw(8'h00, 1'b0, 2'd0, 2'd0);
      send_raw(8'hC3, 1'b0, 2'd1, 2'd1);
   endtask

   // A new start drops a half-read entry and restarts at bit zero.
   task automatic test_restart_mid_packet();
      send_raw(8'h5A, 1'b1, 2'd2, 2'd2);
      send_raw(8'hC3, 1'b0, 2'd2, 2'd2);
      send_raw(8'h3C, 1'b1, 2'd1, 2'd1);
      send_raw(8'h81, 1'b0, 2'd1, 2'd1);
      send_raw(8'h7E, 1'b0, 2'd1, 2'd1);
   endtask

   // Mostly well-formed packets with random content, plus short broken
   // packets and noise with stray starts.
   task automatic test_random_packets();
      item_type it;
      int       kind;
      int       len;
      int       sent;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         kind          = $urandom_range(0, 19);
         source_steady = ($urandom_range(0, 3) == 0);
         sink_style    = ($urandom_range(0, 3) == 0) ? SINK_STEADY : SINK_BURSTY;
         it.rx_antennas = ANT_W'($urandom_range(0, 3));
         it.tx_antennas = ANT_W'($urandom_range(0, 3));
         if (kind < 8) begin
            // Small antenna products, so that whole packets fit the budget.
            it.rx_antennas = ANT_W'($urandom_range(0, 2));
            it.tx_antennas = (it.rx_antennas == 2) ? ANT_W'($urandom_range(0, 1)) :
                                                     ANT_W'($urandom_range(0, 2));
         end
         if (kind < 14) begin
            len = (GROUPS * (SKIP_LEN + 2 * BYTE_W * clamp_antennas(it.rx_antennas) *
                   clamp_antennas(it.tx_antennas)) + 7) / 8;
            if (len > 140)
               len = $urandom_range(20, 60);
            else
               len = len + $urandom_range(0, 4);
         end else if (kind < 17) begin
            len = $urandom_range(1, 15);
         end else begin
            len = $urandom_range(4, 20);
         end
         for (int n = 0; n < len; n++) begin
            it.data_byte = BYTE_W'($urandom_range(0, 255));
            if (kind < 17)
               it.packet_start = (n == 0);
            else
               it.packet_start = ($urandom_range(0, 15) == 0);
            send_byte(it);
            it.rx_antennas = ANT_W'($urandom_range(0, 3));
            it.tx_antennas = ANT_W'($urandom_range(0, 3));
            sent++;
         end
      end
   endtask

   // The receiver alternates ready and stalled runs of random length.
   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_open = !sink_open;
         if (sink_open)
            sink_left = $urandom_range(1, 20);
         else if ($urandom_range(0, 7) == 0)
            sink_left = $urandom_range(20, 30);
         else
            sink_left = $urandom_range(1, 6);
      end
      sink_left--;
      rsp_bus.ready <= sink_open || (sink_style == SINK_STEADY);
   end

   // Each result transaction is matched against the oldest expected entry.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_entries.size() == 0) begin
            report_error($sformatf("entry with none expected: sc %0d tx %0d rx %0d",
                                   rsp_bus.subcarrier, rsp_bus.tx_index, rsp_bus.rx_index));
         end else begin
            wanted = expected_entries.pop_front();
            entries_checked++;
            if (wanted.last_entry)
               packets_finished++;
            if (rsp_bus.real_part !== wanted.real_part)
               report_error($sformatf("real_part got %0d want %0d",
                                      rsp_bus.real_part, wanted.real_part));
            if (rsp_bus.imag_part !== wanted.imag_part)
               report_error($sformatf("imag_part got %0d want %0d",
                                      rsp_bus.imag_part, wanted.imag_part));
            if (rsp_bus.subcarrier !== wanted.subcarrier)
               report_error($sformatf("subcarrier got %0d want %0d",
                                      rsp_bus.subcarrier, wanted.subcarrier));
            if (rsp_bus.tx_index !== wanted.tx_index)
               report_error($sformatf("tx_index got %0d want %0d",
                                      rsp_bus.tx_index, wanted.tx_index));
            if (rsp_bus.rx_index !== wanted.rx_index)
               report_error($sformatf("rx_index got %0d want %0d",
                                      rsp_bus.rx_index, wanted.rx_index));
            if (rsp_bus.last_entry !== wanted.last_entry)
               report_error($sformatf("last_entry got %0b want %0b",
                                      rsp_bus.last_entry, wanted.last_entry));
         end
      end
   end

   // Watchdog: too long without a transaction on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d entries outstanding",
                  idle_cycles, expected_entries.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.data_byte    = '0;
      req_bus.packet_start = 1'b0;
      req_bus.rx_antennas  = '0;
      req_bus.tx_antennas  = '0;
      rsp_bus.ready        = 1'b0;
      source_steady        = 1'b0;
      burst_left           = 0;
      sink_style           = SINK_BURSTY;
      sink_open            = 1'b0;
      sink_left            = 0;
      error_count          = 0;
      bytes_sent           = 0;
      starts_sent          = 0;
      entries_checked      = 0;
      packets_finished     = 0;
      idle_cycles          = 0;

      // The parser comes out of reset idle until the first start.
      parse_phase = SKIP_FIELD;
      field_bits  = '0;
      real_hold   = '0;
      field_pos   = 0;
      sc_idx      = 0;
      entry_idx   = 0;
      ant_rx      = 1;
      ant_tx      = 1;
      parse_idle  = 1'b1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_bytes_before_start();
      test_value_extremes();
      test_zero_tx_count();
      test_restart_mid_packet();
      test_random_packets();

      // Drain: keep the receiver ready until every entry has come back.
      req_bus.valid <= 1'b0;
      sink_style = SINK_STEADY;
      while (expected_entries.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d payload bytes with %0d packet starts.", bytes_sent, starts_sent);
      $display("Checked %0d channel entries, %0d of them closing a packet; %0d errors.",
               entries_checked, packets_finished, error_count);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
